@@ src/mbca_pkg.sv @@
// ----------------------------------------------------------------------------
// mbca_pkg
// Shared types and constants of the Margolus block automaton engine:
// command and result codes, register indexes, sequencer states and the
// register file view.
// ----------------------------------------------------------------------------
package mbca_pkg;

  // Tile index width inside a run: a grid is at most 64 x 64 tiles.
  localparam int IDX_W = 13;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Result kinds
  localparam logic KIND_READ     = 1'b0;
  localparam logic KIND_RUN_DONE = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_RULE_TABLE      = 3'd0;
  localparam logic [2:0] REG_WIDTH_TILES     = 3'd1;
  localparam logic [2:0] REG_HEIGHT_TILES    = 3'd2;
  localparam logic [2:0] REG_ODD_FIRST       = 3'd3;
  localparam logic [2:0] REG_ITERATION_COUNT = 3'd4;

  localparam logic [63:0] RULE_RESET = 64'hFEDC_BA98_7654_3210;

  // Neighbor roles of an odd step; bit 1 selects the north row, bit 0 the
  // west column.
  localparam logic [1:0] ROLE_CENTER    = 2'd0;
  localparam logic [1:0] ROLE_WEST      = 2'd1;
  localparam logic [1:0] ROLE_NORTH     = 2'd2;
  localparam logic [1:0] ROLE_NORTHWEST = 2'd3;

  // Gather / scatter masks of the odd partition
  localparam logic [63:0] MASK_CI_LO = 64'h1555_1555_1555_1555;
  localparam logic [63:0] MASK_CI_HI = 64'h0000_2aaa_2aaa_2aaa;
  localparam logic [63:0] MASK_W     = 64'h0000_0000_0000_5554;
  localparam logic [63:0] MASK_N_HI  = 64'h0002_0002_0002_0002;
  localparam logic [63:0] MASK_N_LO  = 64'h0001_0001_0001_0000;

  typedef struct packed {
    logic [63:0] rule_table;
    logic [6:0]  width_tiles;
    logic [6:0]  height_tiles;
    logic        odd_first;
    logic [15:0] iteration_count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIMS,
    ST_FIT,
    ST_STEP_START,
    ST_EVEN,
    ST_CLEAR,
    ST_GATHER,
    ST_SCATTER,
    ST_STEP_END,
    ST_DONE
  } state_t;

endpackage

@@ src/mbca_if.sv @@
// ----------------------------------------------------------------------------
// mbca_if
// Valid/ready stream interfaces: command channel and result channel.
// ----------------------------------------------------------------------------
interface mbca_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [11:0] tile_address;
  logic [63:0] load_word;

  modport source (output valid, cmd, tile_address, load_word, input ready);
  modport sink   (input valid, cmd, tile_address, load_word, output ready);
endinterface

interface mbca_rsp_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [63:0] read_word;

  modport source (output valid, result_kind, read_word, input ready);
  modport sink   (input valid, result_kind, read_word, output ready);
endinterface

@@ src/mbca_ram.sv @@
// ----------------------------------------------------------------------------
// mbca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/mbca_lookup.sv @@
// ----------------------------------------------------------------------------
// mbca_lookup
// Block rule unit: replaces each of the sixteen nibbles of a word by the
// rule table entry it selects.
// ----------------------------------------------------------------------------
module mbca_lookup (
  input  logic [63:0] rule_table,
  input  logic [63:0] word_in,
  output logic [63:0] word_out
);

  always_comb begin
    word_out = '0;
    for (int k = 0; k < 16; k++) begin
      word_out[4*k +: 4] = rule_table[{word_in[4*k +: 4], 2'b00} +: 4];
    end
  end

endmodule

@@ src/mbca_cfg.sv @@
// ----------------------------------------------------------------------------
// mbca_cfg
// APB register file: rule table, grid size, start phase, step count.
// ----------------------------------------------------------------------------
module mbca_cfg
  import mbca_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rule_table      <= RULE_RESET;
      cfg.width_tiles     <= 7'd1;
      cfg.height_tiles    <= 7'd1;
      cfg.odd_first       <= 1'b0;
      cfg.iteration_count <= 16'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RULE_TABLE:      cfg.rule_table      <= pwdata;
        REG_WIDTH_TILES:     cfg.width_tiles     <= pwdata[6:0];
        REG_HEIGHT_TILES:    cfg.height_tiles    <= pwdata[6:0];
        REG_ODD_FIRST:       cfg.odd_first       <= pwdata[0];
        REG_ITERATION_COUNT: cfg.iteration_count <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RULE_TABLE:      prdata = cfg.rule_table;
      REG_WIDTH_TILES:     prdata = {57'd0, cfg.width_tiles};
      REG_HEIGHT_TILES:    prdata = {57'd0, cfg.height_tiles};
      REG_ODD_FIRST:       prdata = {63'd0, cfg.odd_first};
      REG_ITERATION_COUNT: prdata = {48'd0, cfg.iteration_count};
      default:             prdata = '0;
    endcase
  end

endmodule

@@ src/margolus_block_automaton_engine.sv @@
// ----------------------------------------------------------------------------
// margolus_block_automaton_engine
// Transfers: a write transfer gives no result. A read command goes to the
//   read state, which loads the result register once it is free, and the
//   block is ready again as it leaves that state.
// Run: register the grid size, shrink the height until the grid fits the
//   store, then per step an even sweep, or a clear pass and a gather and
//   scatter per tile. Not ready while a run is in progress.
// Rate is set by the single read port of each tile store: one tile per cycle
//   on an even step; a clear pass, 4 reads plus 4 read-modify-writes per tile
//   on an odd step.
// Reset: sync, active high; clears control and registers, tile stores undefined.
// ----------------------------------------------------------------------------
module margolus_block_automaton_engine
  import mbca_pkg::*;
#(
  parameter int MAX_TILES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  mbca_req_if.sink    req,
  mbca_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int          AW    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam logic [16:0] MAX_T = 17'(MAX_TILES);
  // widest grid row: 64 tiles, or the whole store if it is smaller
  localparam logic [6:0]  W_LIM = 7'((MAX_TILES < 64) ? MAX_TILES : 64);
  localparam logic [6:0]  H_LIM = 7'd64;

  // --------------------------------------------------------------------------
  // Odd-partition bit routing. Each tile feeds a lookup word from itself and
  // its west, north and northwest neighbors; the result is routed back to the
  // same four tiles. The destination pieces are disjoint and cover the word.
  // --------------------------------------------------------------------------
  function automatic logic [63:0] gather_piece(input logic [1:0] role,
                                               input logic [63:0] s);
    logic [63:0] p;
    case (role)
      ROLE_CENTER: p = ((s & MASK_CI_LO) << 3) | ((s & MASK_CI_HI) << 17);
      ROLE_WEST:   p = (s >> 47) & MASK_W;
      ROLE_NORTH:  p = ((s >> 13) & MASK_N_HI) | ((s << 1) & MASK_N_LO);
      default:     p = {63'd0, s[63]};
    endcase
    return p;
  endfunction

  function automatic logic [63:0] scatter_piece(input logic [1:0] role,
                                                input logic [63:0] r);
    logic [63:0] p;
    case (role)
      ROLE_CENTER: p = ((r >> 3) & MASK_CI_LO) | ((r >> 17) & MASK_CI_HI);
      ROLE_WEST:   p = (r & MASK_W) << 47;
      ROLE_NORTH:  p = ((r & MASK_N_HI) << 13) | ((r & MASK_N_LO) >> 1);
      default:     p = {r[0], 63'd0};
    endcase
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  cfg_t             cfg;
  state_t           state, state_next;
  logic             active;          // store holding the current grid (0: a)
  logic [6:0]       w_r, h_r;        // effective grid size
  logic [IDX_W-1:0] n_r;             // tiles in the grid
  logic [IDX_W-1:0] cnt;             // sweep counter (even step, clear)
  logic [IDX_W-1:0] pidx;            // index of the read in flight
  logic             pend;            // even step: a read is in flight
  logic [5:0]       x, y;            // current tile of an odd step
  logic [IDX_W-1:0] rb, nb;          // row base of this row and the north row
  logic [2:0]       sub;             // odd step sub-cycle
  logic [15:0]      k;               // steps left
  logic             phase;           // 1: next step uses the odd partition
  logic [63:0]      g;               // gathered word
  logic [63:0]      r;               // looked-up word to scatter
  logic [11:0]      addr_r;
  logic             addr_ok;
  logic             out_valid;
  logic             out_kind;
  logic [63:0]      out_word;

  // --------------------------------------------------------------------------
  // Combinational
  // --------------------------------------------------------------------------
  logic             in_fire, in_ok, cur_we, out_free, out_load, last_tile;
  logic [6:0]       gw, gh;
  logic [5:0]       xw;
  logic [1:0]       role;
  logic [IDX_W-1:0] tile_idx;
  logic [AW-1:0]    src_raddr, dst_raddr;
  logic             dst_we;
  logic [IDX_W-1:0] dst_idx;
  logic [63:0]      dst_wdata;
  logic [63:0]      src_rdata, dst_rdata;
  logic [63:0]      lookup_in, lookup_out;

  logic             a_we, b_we;
  logic [AW-1:0]    a_waddr, b_waddr, a_raddr, b_raddr;
  logic [63:0]      a_wdata, b_wdata, a_rdata, b_rdata;

  assign req.ready = (state == ST_IDLE);
  assign in_fire   = req.valid & req.ready;
  assign in_ok     = 17'(req.tile_address) < MAX_T;
  assign cur_we    = in_fire && (req.cmd == CMD_WRITE) && in_ok;
  assign out_free  = !out_valid || rsp.ready;
  // result register takes a new result this cycle
  assign out_load  = out_free && ((state == ST_READ) || (state == ST_DONE));

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.read_word   = out_word;

  // size clamps; a zero dimension counts as one
  assign gw = (cfg.width_tiles == 7'd0) ? 7'd1 :
              (cfg.width_tiles > W_LIM) ? W_LIM : cfg.width_tiles;
  assign gh = (cfg.height_tiles == 7'd0) ? 7'd1 :
              (cfg.height_tiles > H_LIM) ? H_LIM : cfg.height_tiles;

  // toroidal neighbor addressing, one shared adder
  assign xw        = (x == 6'd0) ? 6'(w_r - 7'd1) : x - 6'd1;
  assign role      = (state == ST_SCATTER) ? sub[2:1] : sub[1:0];
  assign tile_idx  = (role[1] ? nb : rb) + IDX_W'(role[0] ? xw : x);
  assign last_tile = ({1'b0, x} == w_r - 7'd1) && ({1'b0, y} == h_r - 7'd1);

  // store steering: source is the current grid, destination the other one
  assign src_rdata = active ? b_rdata : a_rdata;
  assign dst_rdata = active ? a_rdata : b_rdata;

  assign a_we    = active ? dst_we : cur_we;
  assign b_we    = active ? cur_we : dst_we;
  assign a_waddr = active ? AW'(dst_idx) : AW'(req.tile_address);
  assign b_waddr = active ? AW'(req.tile_address) : AW'(dst_idx);
  assign a_wdata = active ? dst_wdata : req.load_word;
  assign b_wdata = active ? req.load_word : dst_wdata;
  assign a_raddr = active ? dst_raddr : src_raddr;
  assign b_raddr = active ? src_raddr : dst_raddr;

  // --------------------------------------------------------------------------
  // Submodules
  // --------------------------------------------------------------------------
  mbca_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // shared rule unit: even-step tiles and odd-step gathered words
  mbca_lookup u_lookup (
    .rule_table (cfg.rule_table),
    .word_in    (lookup_in),
    .word_out   (lookup_out)
  );

  mbca_ram #(.WIDTH(64), .DEPTH(MAX_TILES)) u_grid_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mbca_ram #(.WIDTH(64), .DEPTH(MAX_TILES)) u_grid_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer: state register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and store controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    src_raddr  = AW'(addr_r);
    dst_raddr  = AW'(tile_idx);
    dst_we     = 1'b0;
    dst_idx    = cnt;
    dst_wdata  = '0;
    lookup_in  = src_rdata;
    case (state)
      ST_IDLE: begin
        src_raddr = AW'(req.tile_address);
        if (in_fire) begin
          case (req.cmd)
            CMD_RUN:  state_next = ST_DIMS;
            CMD_READ: state_next = ST_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIMS: begin
        state_next = ST_FIT;
      end
      ST_FIT: begin
        // shrink height a row at a time until the grid fits the store
        if (!(17'(n_r) > MAX_T)) begin
          state_next = ST_STEP_START;
        end
      end
      ST_STEP_START: begin
        if (k == 16'd0) begin
          state_next = ST_DONE;
        end else if (phase) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_EVEN;
        end
      end
      ST_EVEN: begin
        // read tile cnt, write back the one read last cycle
        src_raddr = AW'(cnt);
        dst_we    = pend;
        dst_idx   = pidx;
        dst_wdata = lookup_out;
        lookup_in = src_rdata;
        if (cnt == n_r) begin
          state_next = ST_STEP_END;
        end
      end
      ST_CLEAR: begin
        dst_we    = 1'b1;
        dst_idx   = cnt;
        dst_wdata = '0;
        if (cnt == n_r - IDX_W'(1)) begin
          state_next = ST_GATHER;
        end
      end
      ST_GATHER: begin
        // sub 0..3 issue the four reads, sub 1..4 collect them
        src_raddr = AW'(tile_idx);
        lookup_in = g | gather_piece(ROLE_NORTHWEST, src_rdata);
        if (sub == 3'd4) begin
          state_next = ST_SCATTER;
        end
      end
      ST_SCATTER: begin
        // even sub: read destination, odd sub: OR in the piece and write
        dst_raddr = AW'(tile_idx);
        dst_idx   = tile_idx;
        dst_we    = sub[0];
        dst_wdata = dst_rdata | scatter_piece(sub[2:1], r);
        if (sub == 3'd7) begin
          state_next = last_tile ? ST_STEP_END : ST_GATHER;
        end
      end
      ST_STEP_END: begin
        state_next = ST_STEP_START;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      sub       <= 3'd0;
      k         <= 16'd0;
      phase     <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            addr_r  <= req.tile_address;
            addr_ok <= in_ok;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_READ;
            out_word  <= addr_ok ? src_rdata : 64'd0;
          end
        end
        ST_DIMS: begin
          w_r   <= gw;
          h_r   <= gh;
          n_r   <= IDX_W'(gw) * IDX_W'(gh);
          k     <= cfg.iteration_count;
          phase <= cfg.odd_first;
        end
        ST_FIT: begin
          if (17'(n_r) > MAX_T) begin
            n_r <= n_r - IDX_W'(w_r);
            h_r <= h_r - 7'd1;
          end
        end
        ST_STEP_START: begin
          cnt  <= '0;
          pend <= 1'b0;
          x    <= 6'd0;
          y    <= 6'd0;
          rb   <= '0;
          nb   <= n_r - IDX_W'(w_r);   // north of row 0 is the last row
          sub  <= 3'd0;
        end
        ST_EVEN: begin
          pend <= (cnt != n_r);
          pidx <= cnt;
          if (cnt != n_r) begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + IDX_W'(1);
        end
        ST_GATHER: begin
          case (sub)
            3'd0: begin
              g   <= '0;
              sub <= sub + 3'd1;
            end
            3'd4: begin
              r   <= lookup_out;
              sub <= 3'd0;
            end
            default: begin
              g   <= g | gather_piece(2'(sub - 3'd1), src_rdata);
              sub <= sub + 3'd1;
            end
          endcase
        end
        ST_SCATTER: begin
          sub <= sub + 3'd1;
          if (sub == 3'd7) begin
            if ({1'b0, x} == w_r - 7'd1) begin
              x  <= 6'd0;
              y  <= y + 6'd1;
              nb <= rb;
              rb <= rb + IDX_W'(w_r);
            end else begin
              x <= x + 6'd1;
            end
          end
        end
        ST_STEP_END: begin
          active <= ~active;
          phase  <= ~phase;
          k      <= k - 16'd1;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_RUN_DONE;
            out_word  <= 64'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // run writes stay inside the grid
  a_dst_in_grid: assert property (@(posedge clk) disable iff (rst)
    dst_we |-> (dst_idx < n_r))
    else $error("destination write outside the grid");

  // buffers swap only at the end of a step
  a_swap_at_step_end: assert property (@(posedge clk) disable iff (rst)
    (state != ST_STEP_END) |=> (active == $past(active)))
    else $error("active buffer changed outside a step end");

  // a step only runs on a grid that fits the store
  a_grid_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVEN || state == ST_GATHER) |-> (17'(n_r) <= MAX_T && n_r != '0))
    else $error("step running on a grid that does not fit");

  // results come only from a read or the end of a run
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_READ || $past(state) == ST_DONE))
    else $error("result produced outside read or run completion");

endmodule

@@ tb/sv/mbca_result_checker.sv @@
// ----------------------------------------------------------------------------
// mbca_result_checker
// Watches the command, result and register ports of the block automaton
// engine. Keeps its own copy of the registers and both tile stores, works
// out the result of each command transfer and compares result transfers in
// order. Reports the mismatch count and the number of results still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mbca_result_checker
  import mbca_pkg::*;
#(
  parameter int MAX_TILES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  mbca_req_if         req,
  mbca_rsp_if         rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          results_owed
);

  // Odd partition: bits gathered from each neighbor into one lookup word
  localparam logic [63:0] NW_BIT    = 64'h0000_0000_0000_0001;
  localparam logic [63:0] N_HI      = 64'h0002_0002_0002_0002;
  localparam logic [63:0] N_LO      = 64'h0001_0001_0001_0000;
  localparam logic [63:0] W_BITS    = 64'h0000_0000_0000_5554;
  localparam logic [63:0] CENTER_LO = 64'h1555_1555_1555_1555;
  localparam logic [63:0] CENTER_HI = 64'h0000_2aaa_2aaa_2aaa;

  typedef struct packed {
    logic        kind;
    logic [63:0] word;
  } tile_result_t;

  cfg_t         regs;
  bit [63:0]    tiles [2][MAX_TILES];
  bit           live;                  // store holding the current grid
  tile_result_t awaited_results [$];

  function automatic logic [63:0] rule_lookup(input logic [63:0] v);
    logic [63:0] r;
    logic [3:0]  nib;
    int          k;
    r = '0;
    for (k = 0; k < 16; k++) begin
      nib = v[4*k +: 4];
      r[4*k +: 4] = regs.rule_table[4*nib +: 4];
    end
    return r;
  endfunction

  // zero reads as one tile, anything past 64 saturates
  function automatic int grid_extent(input logic [6:0] d);
    if (d == 7'd0) return 1;
    if (d > 7'd64) return 64;
    return int'(d);
  endfunction

  task automatic even_step(input bit src, input int n);
    int i;
    for (i = 0; i < n; i++) tiles[~src][i] = rule_lookup(tiles[src][i]);
  endtask

  task automatic odd_step(input bit src, input int w, input int h);
    int          x, y, xw, yn, ci, wi, ni, nwi, i;
    logic [63:0] g, r;
    bit          dst;
    dst = ~src;
    for (i = 0; i < w * h; i++) tiles[dst][i] = '0;
    for (y = 0; y < h; y++) begin
      yn = (y == 0) ? h - 1 : y - 1;
      for (x = 0; x < w; x++) begin
        xw  = (x == 0) ? w - 1 : x - 1;
        ci  = y * w + x;
        wi  = y * w + xw;
        ni  = yn * w + x;
        nwi = yn * w + xw;
        g = ((tiles[src][nwi] >> 63) & NW_BIT)
          | ((tiles[src][ni] >> 13) & N_HI)
          | ((tiles[src][ni] << 1) & N_LO)
          | ((tiles[src][wi] >> 47) & W_BITS)
          | ((tiles[src][ci] & CENTER_LO) << 3)
          | ((tiles[src][ci] & CENTER_HI) << 17);
        r = rule_lookup(g);
        tiles[dst][nwi] |= (r & NW_BIT) << 63;
        tiles[dst][ni]  |= (r & N_HI) << 13;
        tiles[dst][ni]  |= (r & N_LO) >> 1;
        tiles[dst][wi]  |= (r & W_BITS) << 47;
        tiles[dst][ci]  |= (r >> 3) & CENTER_LO;
        tiles[dst][ci]  |= (r >> 17) & CENTER_HI;
      end
    end
  endtask

  // Whole run: partitions alternate from the first-step partition register,
  // stores swap each step
  task automatic evolve_grid();
    int w, h, k;
    bit odd;
    w   = grid_extent(regs.width_tiles);
    h   = grid_extent(regs.height_tiles);
    // grid limited to the store size
    if (w > MAX_TILES) w = MAX_TILES;
    if (w * h > MAX_TILES) h = MAX_TILES / w;
    odd = regs.odd_first;
    for (k = 0; k < int'(regs.iteration_count); k++) begin
      if (odd) odd_step(live, w, h);
      else even_step(live, w * h);
      live = ~live;
      odd  = ~odd;
    end
  endtask

  always @(posedge clk) begin : watch
    tile_result_t want;
    if (rst) begin
      regs.rule_table      = RULE_RESET;
      regs.width_tiles     = 7'd1;
      regs.height_tiles    = 7'd1;
      regs.odd_first       = 1'b0;
      regs.iteration_count = 16'd0;
      live = 1'b0;
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected: kind %0d word %h",
                   $time, rsp.result_kind, rsp.read_word);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp.result_kind !== want.kind) begin
            $display("%0t: result_kind expected %0d, got %0d",
                     $time, want.kind, rsp.result_kind);
            mismatch_count++;
          end
          if (rsp.read_word !== want.word) begin
            $display("%0t: read_word expected %h, got %h",
                     $time, want.word, rsp.read_word);
            mismatch_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_RULE_TABLE:      regs.rule_table      = pwdata;
          REG_WIDTH_TILES:     regs.width_tiles     = pwdata[6:0];
          REG_HEIGHT_TILES:    regs.height_tiles    = pwdata[6:0];
          REG_ODD_FIRST:       regs.odd_first       = pwdata[0];
          REG_ITERATION_COUNT: regs.iteration_count = pwdata[15:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.cmd)
          CMD_WRITE: tiles[live][req.tile_address] = req.load_word;
          CMD_RUN: begin
            evolve_grid();
            awaited_results.push_back('{kind: KIND_RUN_DONE, word: 64'd0});
          end
          CMD_READ:
            awaited_results.push_back('{kind: KIND_READ,
                                        word: tiles[live][req.tile_address]});
          default: ;  // reserved code is dropped
        endcase
      end
    end
    results_owed = awaited_results.size();
  end

endmodule

@@ tb/sv/tb_margolus_block_automaton_engine.sv @@
// ----------------------------------------------------------------------------
// tb_margolus_block_automaton_engine
// Stimulus and verdict for the block automaton engine. Writes the registers
// between phases, fills the grid, then drives directed and random tile
// writes, reads and runs with random gaps and result stalls. Checking is
// done by mbca_result_checker, instantiated beside the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_margolus_block_automaton_engine;
  import mbca_pkg::*;

  localparam int          TILE_SLOTS    = 4096;
  localparam logic [1:0]  CMD_RESERVED  = 2'd3;   // accepted and dropped
  localparam int          SETTLE_CYCLES = 8;
  // Slowest clean run is the 65535-step run on a single tile; leave plenty
  // of headroom.
  localparam longint      CYCLE_LIMIT   = 4_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;

  int          mismatch_count;
  int          results_owed;
  longint      cycle_count;

  // Stimulus side view of the stores: which tiles hold a defined value in
  // each store, so a read or a run never touches an unwritten tile.
  bit          tile_known [2][TILE_SLOTS];
  bit          cur_buf;
  int          grid_w, grid_h;
  logic [15:0] step_count;
  bit          gapless;

  // result side stall control
  int          stall_left;
  bit          steady;

  mbca_req_if req_ch();
  mbca_rsp_if rsp_ch();

  margolus_block_automaton_engine #(
    .MAX_TILES (TILE_SLOTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mbca_result_checker #(
    .MAX_TILES (TILE_SLOTS)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hard stop: also catches a result that never shows up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL margolus_block_automaton_engine");
      $finish;
    end
  end

  // Result side back-pressure. Mostly short stalls, now and then a long one;
  // it also flips at random into or out of a stall-free stretch.
  initial begin : result_stalls
    int r;
    rsp_ch.ready = 1'b0;
    stall_left = 0;
    steady = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(299) == 0) steady = ~steady;
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        r = $urandom_range(99);
        if (!steady && r < 25) begin
          stall_left = (r < 3) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        end
      end
    end
  end

  function automatic int grid_extent(input logic [6:0] d);
    if (d == 7'd0) return 1;
    if (d > 7'd64) return 64;
    return int'(d);
  endfunction

  function automatic int pick_gap();
    int r;
    if (gapless) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One command transfer. valid stays high after the transfer so the next
  // call can follow back to back; a gap lowers it at the next falling edge.
  task automatic push_command(input logic [1:0] code, input logic [11:0] addr,
                              input logic [63:0] word);
    int gap, i;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= code;
    req_ch.tile_address <= addr;
    req_ch.load_word    <= word;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    case (code)
      CMD_WRITE: tile_known[cur_buf][addr] = 1'b1;
      CMD_RUN: begin
        // after any step the grid part of both stores is defined
        if (step_count != 16'd0) begin
          for (i = 0; i < grid_w * grid_h; i++) begin
            tile_known[0][i] = 1'b1;
            tile_known[1][i] = 1'b1;
          end
          cur_buf ^= step_count[0];
        end
      end
      default: ;
    endcase
  endtask

  // Stop sending and wait until every owed result has its transfer, then let
  // the engine settle in case the last command was a write still in flight.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, then access cycle; written on the edge with pready high.
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_item(input int run_pct);
    int          r;
    logic [11:0] addr;
    r = $urandom_range(99);
    // occasional full stop of the sender until all results are back
    if ($urandom_range(49) == 0) drain();
    if (r < run_pct) begin
      push_command(CMD_RUN, 12'($urandom), pick_word());
    end else if (r < run_pct + 5) begin
      push_command(CMD_RESERVED, 12'($urandom), pick_word());
    end else if (r < run_pct + 45) begin
      // half inside the grid, half anywhere already written
      addr = $urandom_range(1) ? 12'($urandom_range(grid_w * grid_h - 1))
                               : 12'($urandom);
      if (!tile_known[cur_buf][addr]) addr = 12'($urandom_range(grid_w * grid_h - 1));
      push_command(CMD_READ, addr, pick_word());
    end else begin
      addr = ($urandom_range(2) == 0) ? 12'($urandom)
                                      : 12'($urandom_range(grid_w * grid_h - 1));
      push_command(CMD_WRITE, addr, pick_word());
    end
  endtask

  // Reconfigure while idle, fill every grid tile of the current store, then
  // a batch of random commands.
  task automatic run_phase(input logic [63:0] rule, input logic [6:0] w,
                           input logic [6:0] h, input logic ph,
                           input logic [15:0] steps, input int count,
                           input int run_pct);
    int i;
    drain();
    reg_write(REG_RULE_TABLE, rule);
    reg_write(REG_WIDTH_TILES, {57'd0, w});
    reg_write(REG_HEIGHT_TILES, {57'd0, h});
    reg_write(REG_ODD_FIRST, {63'd0, ph});
    reg_write(REG_ITERATION_COUNT, {48'd0, steps});
    grid_w     = grid_extent(w);
    grid_h     = grid_extent(h);
    step_count = steps;
    gapless    = ($urandom_range(2) == 0);
    for (i = 0; i < grid_w * grid_h; i++) push_command(CMD_WRITE, 12'(i), pick_word());
    for (i = 0; i < count; i++) random_item(run_pct);
  endtask

  // Random settings; grids stay at 64 tiles or less so runs stay short.
  task automatic random_phase();
    logic [63:0] rule;
    logic [6:0]  w, h;
    int          sel;
    rule = ($urandom_range(9) == 0) ? RULE_RESET : {$urandom, $urandom};
    sel  = $urandom_range(9);
    if (sel == 0) begin
      w = 7'($urandom_range(65, 127));
      h = 7'd1;
    end else if (sel == 1) begin
      w = 7'd1;
      h = 7'($urandom_range(9, 64));
    end else if (sel == 2) begin
      w = 7'($urandom_range(9, 64));
      h = 7'd1;
    end else begin
      w = 7'($urandom_range(0, 8));
      h = 7'($urandom_range(0, 8));
    end
    run_phase(rule, w, h, 1'($urandom_range(1)), 16'($urandom_range(0, 4)), 20, 10);
  endtask

  initial begin : stimulus
    int p;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_WRITE;
    req_ch.tile_address = '0;
    req_ch.load_word    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    cur_buf    = 1'b0;
    grid_w     = 1;
    grid_h     = 1;
    step_count = 16'd0;
    gapless    = 1'b0;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed, on reset settings (identity rule, one tile, no steps):
    // word and address extremes, tiles outside the grid, reserved code,
    // a run with zero steps.
    push_command(CMD_WRITE, 12'h000, '1);
    push_command(CMD_READ, 12'h000, '0);
    push_command(CMD_WRITE, 12'hFFF, '0);
    push_command(CMD_READ, 12'hFFF, '1);
    push_command(CMD_WRITE, 12'hAAA, 64'hAAAA_AAAA_AAAA_AAAA);
    push_command(CMD_WRITE, 12'h555, 64'h5555_5555_5555_5555);
    push_command(CMD_READ, 12'hAAA, '0);
    push_command(CMD_READ, 12'h555, '0);
    push_command(CMD_RESERVED, 12'hFFF, '1);
    push_command(CMD_RUN, 12'h000, '0);
    push_command(CMD_READ, 12'h000, '0);
    push_command(CMD_RESERVED, 12'h000, '0);
    push_command(CMD_READ, 12'hFFF, '0);

    // Register extremes: zero width and height with an odd start and no
    // steps, all-ones rule on the widest row, tallest column, saturated
    // width with an odd number of steps.
    run_phase(64'd0, 7'd0, 7'd0, 1'b1, 16'd0, 30, 15);
    run_phase('1, 7'd64, 7'd1, 1'b0, 16'd3, 30, 10);
    run_phase({$urandom, $urandom}, 7'd1, 7'd64, 1'b1, 16'd2, 30, 10);
    run_phase({$urandom, $urandom}, 7'd127, 7'd1, 1'b1, 16'd5, 30, 10);

    // Full step count on a single tile: the longest run, done once.
    run_phase({$urandom, $urandom}, 7'd1, 7'd1, 1'($urandom_range(1)), 16'hFFFF, 4, 0);
    push_command(CMD_RUN, 12'h000, '0);
    push_command(CMD_READ, 12'h000, '0);

    for (p = 0; p < 6; p++) random_phase();

    drain();
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("PASS margolus_block_automaton_engine");
    end else begin
      $display("FAIL margolus_block_automaton_engine");
    end
    $finish;
  end

endmodule
